// ===== hdl/rhp_pkg.sv =====
// Shared constants for the RGB histogram with peak tracking.
// Used by the core and the port checker. No dependencies.
package rhp_pkg;

  localparam int unsigned     BINS_DEF      = 256;
  localparam longint unsigned COUNT_MAX_DEF = 64'd1048575;

  localparam int CHANNELS = 3;
  localparam int SAMPLE_W = 8;
  localparam int CMD_W    = 2;
  localparam int BAND_W   = 2;
  localparam int OUT_W    = 20;
  localparam int S_DATA_W = 4 * SAMPLE_W;
  localparam int M_DATA_W = 4 * OUT_W;

  localparam logic [CMD_W-1:0] CMD_ACC   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

  localparam logic [BAND_W-1:0] BAND_RED   = 2'd0;
  localparam logic [BAND_W-1:0] BAND_GREEN = 2'd1;
  localparam logic [BAND_W-1:0] BAND_BLUE  = 2'd2;

endpackage

// ===== hdl/rhp_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module rhp_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== hdl/rgb_histogram_with_peak_core.sv =====
// RGB histogram core: three bin-count RAMs with read-modify-write and peak tracking.
// Depends on rhp_pkg and rhp_ram.
//
//  channel  | direction | tdata (low bit up)                          | tuser
//  ---------+-----------+---------------------------------------------+------
//  s_*      | in        | red, green, blue, bin_index                 | cmd
//  m_*      | out       | red_count, green_count, blue_count, peak    | -
//  cfg_*    | in        | band_select (write only)                    | -
//
// One beat per cycle sustained while the output is not stalled; the RAM read is registered at
// the accepting edge, then the update is computed and the result registered in the output
// register. Bin reuse on consecutive beats is forwarded.
// Reset sweeps all BINS entries, one per cycle, with s_tready low; a clear holds s_tready low
// while it waits in stage 1 and through the sweep that it starts.
// s_tready follows m_tready through the output register; a stall holds the whole pipe.
module rgb_histogram_with_peak_core #(
  parameter int unsigned     BINS      = rhp_pkg::BINS_DEF,
  parameter longint unsigned COUNT_MAX = rhp_pkg::COUNT_MAX_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [rhp_pkg::S_DATA_W-1:0]  s_tdata,   // red, green, blue, bin_index
  input  logic [rhp_pkg::CMD_W-1:0]     s_tuser,   // cmd
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [rhp_pkg::M_DATA_W-1:0]  m_tdata,   // red_count, green_count, blue_count, peak_count
  input  logic                          cfg_we,
  input  logic [rhp_pkg::BAND_W-1:0]    cfg_wdata  // band_select
);

  localparam int AW = $clog2(BINS);
  localparam int CW = $clog2(COUNT_MAX + 64'd1);
  localparam int NC = rhp_pkg::CHANNELS;
  localparam int SW = rhp_pkg::SAMPLE_W;
  localparam int OW = rhp_pkg::OUT_W;
  localparam logic [AW-1:0] LAST_BIN = AW'(BINS - 1);
  localparam logic [CW-1:0] CNT_TOP  = CW'(COUNT_MAX);

  function automatic logic [AW-1:0] bin_of(input logic [SW-1:0] v);
    if (32'(v) >= BINS) return LAST_BIN;
    return AW'(v);
  endfunction

  logic [rhp_pkg::BAND_W-1:0] band_select;
  logic                       sweep_active;
  logic [AW-1:0]              sweep_addr;
  logic                       s1_valid;
  logic [rhp_pkg::CMD_W-1:0]  s1_cmd;
  logic [AW-1:0]              s1_addr   [NC];
  logic                       last_wr_valid;
  logic [AW-1:0]              last_addr [NC];
  logic [CW-1:0]              last_data [NC];
  logic [CW-1:0]              peak;
  logic [CW-1:0]              peak_next;

  logic          advance;
  logic          accept;
  logic          s1_fire;
  logic          wr_en;
  logic [AW-1:0] rd_addr [NC];
  logic [AW-1:0] wr_addr [NC];
  logic [CW-1:0] wr_data [NC];
  logic [CW-1:0] rdata   [NC];
  logic [CW-1:0] cur     [NC];
  logic [CW-1:0] inc     [NC];
  logic [CW-1:0] res     [NC];

  assign advance  = !m_tvalid || m_tready;
  assign s_tready = advance && !sweep_active && !(s1_valid && (s1_cmd == rhp_pkg::CMD_CLEAR));
  assign accept   = s_tvalid && s_tready;
  assign s1_fire  = s1_valid && advance;
  assign wr_en    = sweep_active || (s1_fire && (s1_cmd == rhp_pkg::CMD_ACC));

  for (genvar c = 0; c < NC; c++) begin : g_chan
    assign rd_addr[c] = (s_tuser == rhp_pkg::CMD_READ) ? bin_of(s_tdata[3*SW +: SW])
                                                       : bin_of(s_tdata[c*SW +: SW]);
    assign cur[c] = (last_wr_valid && (last_addr[c] == s1_addr[c])) ? last_data[c] : rdata[c];
    assign inc[c] = (cur[c] == CNT_TOP) ? cur[c] : cur[c] + CW'(1);
    assign wr_addr[c] = sweep_active ? sweep_addr : s1_addr[c];
    assign wr_data[c] = sweep_active ? '0 : inc[c];

    always_comb begin
      case (s1_cmd)
        rhp_pkg::CMD_ACC:  res[c] = inc[c];
        rhp_pkg::CMD_READ: res[c] = cur[c];
        default:           res[c] = '0;
      endcase
    end

    rhp_ram #(
      .WIDTH (CW),
      .DEPTH (BINS)
    ) u_bins (
      .clk   (clk),
      .we    (wr_en),
      .waddr (wr_addr[c]),
      .wdata (wr_data[c]),
      .re    (accept),
      .raddr (rd_addr[c]),
      .rdata (rdata[c])
    );
  end

  always_comb begin
    peak_next = peak;
    if (s1_fire) begin
      case (s1_cmd)
        rhp_pkg::CMD_ACC: begin
          case (band_select)
            rhp_pkg::BAND_RED:   if (inc[0] > peak) peak_next = inc[0];
            rhp_pkg::BAND_GREEN: if (inc[1] > peak) peak_next = inc[1];
            rhp_pkg::BAND_BLUE:  if (inc[2] > peak) peak_next = inc[2];
            default:             peak_next = peak;
          endcase
        end
        rhp_pkg::CMD_CLEAR: peak_next = '0;
        default:            peak_next = peak;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      band_select   <= rhp_pkg::BAND_RED;
      sweep_active  <= 1'b1;
      sweep_addr    <= '0;
      s1_valid      <= 1'b0;
      last_wr_valid <= 1'b0;
      peak          <= '0;
      m_tvalid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        band_select <= cfg_wdata;
      end
      if (sweep_active) begin
        if (sweep_addr == LAST_BIN) begin
          sweep_active <= 1'b0;
          sweep_addr   <= '0;
        end else begin
          sweep_addr <= sweep_addr + AW'(1);
        end
      end
      if (s1_fire && (s1_cmd == rhp_pkg::CMD_CLEAR)) begin
        sweep_active  <= 1'b1;
        last_wr_valid <= 1'b0;
      end
      if (s1_fire && (s1_cmd == rhp_pkg::CMD_ACC)) begin
        last_wr_valid <= 1'b1;
      end
      if (advance) begin
        s1_valid <= accept;
        m_tvalid <= s1_valid;
      end
      peak <= peak_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_cmd <= s_tuser;
      for (int c = 0; c < NC; c++) begin
        s1_addr[c] <= rd_addr[c];
      end
    end
    if (s1_fire && (s1_cmd == rhp_pkg::CMD_ACC)) begin
      for (int c = 0; c < NC; c++) begin
        last_addr[c] <= s1_addr[c];
        last_data[c] <= inc[c];
      end
    end
    if (s1_fire) begin
      m_tdata <= {OW'(peak_next), OW'(res[2]), OW'(res[1]), OW'(res[0])};
    end
  end

endmodule

// ===== hdl/rhp_checker.sv =====
// Port-level checker for the RGB histogram core, bound to the top level.
// Depends on rhp_pkg and rgb_histogram_with_peak_core.
module rhp_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [rhp_pkg::CMD_W-1:0]     s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [rhp_pkg::M_DATA_W-1:0]  m_tdata
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result beat changed while stalled");

  a_reset_sweep: assert property (@(posedge clk)
    rst |=> !s_tready && !m_tvalid)
    else $error("input open or result shown right after reset");

  a_clear_blocks: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == rhp_pkg::CMD_CLEAR) |=> !s_tready)
    else $error("input taken right after a clear");

  a_ready_needs_room: assert property (@(posedge clk) disable iff (rst)
    s_tready |-> !m_tvalid || m_tready)
    else $error("input taken while output stalled");

endmodule

bind rgb_histogram_with_peak_core rhp_checker u_rhp_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
